[rtl/msam_pkg.sv]
package msam_pkg;

  localparam int NumSourcesDefault = 8;
  localparam int FifoDepthDefault  = 1024;
  localparam int MaxFrame          = 64;
  localparam int FrameLenWidth     = 7;
  localparam int DropLimitWidth    = 11;
  localparam int SampleWidth       = 16;

  localparam logic [6:0]  FrameLenReset  = 7'd64;
  localparam logic [10:0] DropLimitReset = 11'd320;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } command_t;

  typedef enum logic {
    REG_FRAME_LEN  = 1'b0,
    REG_DROP_LIMIT = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUNT,
    ST_READ,
    ST_WAIT,
    ST_DIV,
    ST_ACC,
    ST_EMIT,
    ST_UPDATE
  } state_t;

  // Requests from the sequencer to the shared divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/msam_divider.sv]
// Signed 16-bit dividend by small unsigned divisor, one quotient bit a cycle,
// truncating toward zero.
module msam_divider #(
  parameter int CountWidth = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  msam_pkg::div_ctrl_t       ctrl,
  input  logic signed [15:0]        dividend,
  input  logic [CountWidth-1:0]     divisor,
  output msam_pkg::div_stat_t       stat,
  output logic signed [15:0]        quotient
);

  logic [15:0]           mag;
  logic [CountWidth:0]   rem;
  logic [15:0]           quo;
  logic                  neg;
  logic [4:0]            step;
  logic                  running;
  logic                  done;
  logic [CountWidth:0]   trial;
  logic [CountWidth+1:0] shifted;

  always_comb begin
    shifted = {rem, mag[15]};
    trial   = shifted[CountWidth:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        running <= 1'b1;
        step    <= '0;
        neg     <= dividend[15];
        mag     <= dividend[15] ? 16'(-dividend) : 16'(dividend);
        rem     <= '0;
        quo     <= '0;
      end else if (running) begin
        mag <= {mag[14:0], 1'b0};
        if (shifted >= {1'b0, {1'b0, divisor}}) begin
          rem <= (CountWidth+1)'(shifted - {1'b0, {1'b0, divisor}});
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[14:0], 1'b0};
        end
        step <= step + 5'd1;
        if (step == 5'd15) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient  = neg ? -$signed(quo) : $signed(quo);
  assign stat.busy = running;
  assign stat.done = done;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> !running) else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running)) else $error("divider done without run");
`endif

endmodule

[rtl/multi_source_audio_mixer_unit.sv]
// Channel  | Signals                                        | Dir
// request  | start, busy, command, source_index, sample_value | in (busy out)
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | in (ready out)
// result   | result_valid, mixed_sample, last_in_frame      | out
//
// A push is accepted in idle and then passes through the update state, which
// writes the count and the sample store.
// A tick first counts the active sources, then for each position visits each
// source: a source that adds nothing is passed over in the read state, one that
// adds a sample goes through read, wait, the shared divide and add, and an emit
// step ends the position; an update pass over all sources follows. A tick with
// no active source ends after the count and the read state.
// Synchronous reset clears counts and pointers; the store needs no clearing.
// Results are strobed for one cycle; the receiver cannot stall.
module multi_source_audio_mixer_unit #(
  parameter int NUM_SOURCES = msam_pkg::NumSourcesDefault,
  parameter int FIFO_DEPTH  = msam_pkg::FifoDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [2:0]         source_index,
  input  logic signed [15:0] sample_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [10:0]        cfg_data,
  output logic               result_valid,
  output logic signed [15:0] mixed_sample,
  output logic               last_in_frame
);

  localparam int SW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = PW + 1;
  localparam int AW = $clog2(NUM_SOURCES + 1);
  localparam int MW = SW + PW;

  logic signed [15:0] store [NUM_SOURCES*FIFO_DEPTH];
  logic [CW-1:0] fill [NUM_SOURCES];
  logic [PW-1:0] rptr [NUM_SOURCES];

  logic [6:0]  frame_len;
  logic [10:0] drop_limit;

  msam_pkg::state_t state, state_next;
  logic [SW-1:0] src;
  logic [6:0]    pos;
  logic [6:0]    len;
  logic [AW-1:0] active;
  logic signed [15:0] acc;
  logic signed [15:0] rd_data;
  logic is_push;
  logic [15:0] push_val;
  logic [2:0]  push_src;
  logic [SW-1:0] push_sel;
  logic        src_last;

  msam_pkg::div_ctrl_t div_ctrl;
  msam_pkg::div_stat_t div_stat;
  logic signed [15:0] quotient;

  msam_divider #(.CountWidth(AW)) u_div (
    .clk(clk), .rst(rst), .ctrl(div_ctrl), .dividend(rd_data),
    .divisor(active), .stat(div_stat), .quotient(quotient)
  );

  assign cfg_ready = (state == msam_pkg::ST_IDLE) && !start;
  assign src_last  = (32'(src) == NUM_SOURCES - 1);
  assign push_sel  = SW'(push_src);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len  <= msam_pkg::FrameLenReset;
      drop_limit <= msam_pkg::DropLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (msam_pkg::reg_index_t'(cfg_index))
        msam_pkg::REG_FRAME_LEN:  frame_len  <= cfg_data[6:0];
        msam_pkg::REG_DROP_LIMIT: drop_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      msam_pkg::ST_IDLE:
        if (start) state_next = (command == msam_pkg::CMD_TICK) ?
                                msam_pkg::ST_COUNT : msam_pkg::ST_UPDATE;
      msam_pkg::ST_COUNT:
        if (src_last) state_next = msam_pkg::ST_READ;
      msam_pkg::ST_READ:
        if (active == '0) state_next = msam_pkg::ST_IDLE;
        else if (fill[src] > CW'(pos)) state_next = msam_pkg::ST_WAIT;
        else state_next = src_last ? msam_pkg::ST_EMIT : msam_pkg::ST_READ;
      msam_pkg::ST_WAIT: state_next = msam_pkg::ST_DIV;
      msam_pkg::ST_DIV:
        if (div_stat.done) state_next = msam_pkg::ST_ACC;
      msam_pkg::ST_ACC:
        state_next = src_last ? msam_pkg::ST_EMIT : msam_pkg::ST_READ;
      msam_pkg::ST_EMIT:
        state_next = (pos + 7'd1 == len) ? msam_pkg::ST_UPDATE : msam_pkg::ST_READ;
      msam_pkg::ST_UPDATE:
        if (is_push || src_last) state_next = msam_pkg::ST_IDLE;
      default: state_next = msam_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != msam_pkg::ST_IDLE);
    div_ctrl = '0;
    div_ctrl.start = (state == msam_pkg::ST_WAIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= msam_pkg::ST_IDLE;
      result_valid <= 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        fill[i] <= '0;
        rptr[i] <= '0;
      end
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      case (state)
        msam_pkg::ST_IDLE: begin
          src    <= '0;
          pos    <= '0;
          acc    <= '0;
          active <= '0;
          is_push  <= (command == msam_pkg::CMD_PUSH);
          push_src <= source_index;
          push_val <= sample_value;
          if (frame_len == 7'd0) len <= 7'd1;
          else if (frame_len > 7'(msam_pkg::MaxFrame)) len <= 7'(msam_pkg::MaxFrame);
          else len <= frame_len;
        end
        msam_pkg::ST_COUNT: begin
          if (fill[src] != '0) active <= active + AW'(1);
          src <= src_last ? '0 : src + SW'(1);
        end
        msam_pkg::ST_READ:
          if (!(fill[src] > CW'(pos)) && !src_last) src <= src + SW'(1);
        msam_pkg::ST_ACC: begin
          acc <= acc + quotient;
          if (!src_last) src <= src + SW'(1);
        end
        msam_pkg::ST_EMIT: begin
          result_valid  <= 1'b1;
          mixed_sample  <= acc;
          last_in_frame <= (pos + 7'd1 == len);
          acc <= '0;
          src <= '0;
          pos <= pos + 7'd1;
        end
        msam_pkg::ST_UPDATE: begin
          if (is_push) begin
            if (32'(push_src) < NUM_SOURCES &&
                fill[push_sel] < CW'(FIFO_DEPTH))
              fill[push_sel] <= fill[push_sel] + CW'(1);
          end else begin
            src <= src + SW'(1);
            if (fill[src] != '0) begin
              if (fill[src] > CW'(len)) begin
                if (32'(fill[src] - CW'(len)) > 32'(drop_limit)) begin
                  fill[src] <= '0;
                  rptr[src] <= '0;
                end else begin
                  fill[src] <= fill[src] - CW'(len);
                  rptr[src] <= rptr[src] + PW'(len);
                end
              end else begin
                fill[src] <= '0;
                rptr[src] <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Sample store: one write port for pushes, one registered read for ticks.
  always_ff @(posedge clk) begin
    if (state == msam_pkg::ST_UPDATE && is_push && 32'(push_src) < NUM_SOURCES &&
        fill[push_sel] < CW'(FIFO_DEPTH))
      store[{push_sel, PW'(rptr[push_sel] + fill[push_sel][PW-1:0])}] <= push_val;
    rd_data <= store[MW'({src, PW'(rptr[src] + PW'(pos))})];
  end

`ifndef ASSERT_OFF
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy) else $error("config taken while busy");
  a_result_in_tick: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == msam_pkg::ST_EMIT)) else $error("stray result");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_in_frame) |-> state == msam_pkg::ST_UPDATE)
    else $error("last sample not followed by update");
  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    32'(active) <= NUM_SOURCES) else $error("active count overflow");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

  class mix_scoreboard;
    logic signed [15:0] store [8][1024];
    int unsigned        fill [8];
    int unsigned        rdptr [8];
    logic [6:0]         frame_len;
    logic [10:0]        drop_limit;
    logic [16:0]        pending [$];
    int                 errors;

    function void clear();
      for (int s = 0; s < 8; s++) begin
        fill[s] = 0;
        rdptr[s] = 0;
      end
      frame_len = msam_pkg::FrameLenReset;
      drop_limit = msam_pkg::DropLimitReset;
      errors = 0;
    endfunction

    function void write_reg(msam_pkg::reg_index_t idx, logic [10:0] data);
      if (idx == msam_pkg::REG_FRAME_LEN) frame_len = data[6:0];
      else drop_limit = data;
    endfunction

    // Updates the mixer state for one accepted request and queues its samples.
    function void note_request(msam_pkg::command_t cmd, logic [2:0] src,
                               logic signed [15:0] val);
      int active, len, acc;
      active = 0;
      if (cmd == msam_pkg::CMD_PUSH) begin
        if (fill[src] < 1024) begin
          store[src][(rdptr[src] + fill[src]) % 1024] = val;
          fill[src]++;
        end
        return;
      end
      for (int s = 0; s < 8; s++) if (fill[s] != 0) active++;
      if (active == 0) return;
      len = frame_len;
      if (len == 0) len = 1;
      if (len > msam_pkg::MaxFrame) len = msam_pkg::MaxFrame;
      for (int j = 0; j < len; j++) begin
        acc = 0;
        for (int s = 0; s < 8; s++)
          if (fill[s] > j) acc += int'(store[s][(rdptr[s] + j) % 1024]) / active;
        pending.push_back({acc[15:0], j + 1 == len});
      end
      for (int s = 0; s < 8; s++) begin
        if (fill[s] == 0) continue;
        if (fill[s] > len) begin
          fill[s] -= len;
          if (fill[s] > drop_limit) begin
            fill[s] = 0;
            rdptr[s] = 0;
          end else begin
            rdptr[s] = (rdptr[s] + len) % 1024;
          end
        end else begin
          fill[s] = 0;
          rdptr[s] = 0;
        end
      end
    endfunction

    function void check_sample(logic signed [15:0] ms, logic last);
      logic [16:0] exp_s;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample %0d last %0b", ms, last);
        return;
      end
      exp_s = pending.pop_front();
      if (exp_s !== {ms, last}) begin
        errors++;
        if (errors <= 10)
          $display("sample mismatch: expected %0d last %0b, got %0d last %0b",
                   $signed(exp_s[16:1]), exp_s[0], ms, last);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               command = 1'b0;
  logic [2:0]         source_index = '0;
  logic signed [15:0] sample_value = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [10:0]        cfg_data = '0;
  logic               result_valid;
  logic signed [15:0] mixed_sample;
  logic               last_in_frame;

  mix_scoreboard sb = new();
  int            idle_cycles = 0;

  multi_source_audio_mixer_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_sample(mixed_sample, last_in_frame);
      if (result_valid || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 60000) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Leaves start high; the caller lowers it only when a gap follows.
  task automatic send_request(msam_pkg::command_t cmd, logic [2:0] src,
                              logic signed [15:0] val);
    start <= 1'b1;
    command <= cmd;
    source_index <= src;
    sample_value <= val;
    do @(posedge clk); while (busy);
    sb.note_request(cmd, src, val);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every queued sample has come and the block has gone idle.
  task automatic drain();
    pause_sender(1);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(msam_pkg::reg_index_t idx, logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_burst(int items, int tick_pct);
    int burst;
    while (items > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && items > 0) begin
        if ($urandom_range(0, 99) < tick_pct)
          send_request(msam_pkg::CMD_TICK, 3'($urandom), 16'($urandom));
        else send_request(msam_pkg::CMD_PUSH, 3'($urandom), rand_sample());
        burst--;
        items--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 30));
    end
  endtask

  initial begin
    logic [10:0] fl, dl;
    sb.clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A tick with every source empty gives nothing.
    send_request(msam_pkg::CMD_TICK, 3'd0, 16'sd0);
    send_request(msam_pkg::CMD_PUSH, 3'd0, 16'sh7fff);
    send_request(msam_pkg::CMD_PUSH, 3'd1, 16'sh8000);
    send_request(msam_pkg::CMD_PUSH, 3'd2, 16'sh7fff);
    send_request(msam_pkg::CMD_PUSH, 3'd3, -16'sd1);
    send_request(msam_pkg::CMD_PUSH, 3'd4, 16'sd0);
    send_request(msam_pkg::CMD_PUSH, 3'd5, 16'sh8000);
    send_request(msam_pkg::CMD_PUSH, 3'd6, 16'sd7);
    send_request(msam_pkg::CMD_PUSH, 3'd7, -16'sd7);
    send_request(msam_pkg::CMD_PUSH, 3'd7, 16'sh7fff);
    send_request(msam_pkg::CMD_TICK, 3'd7, 16'shffff);
    send_request(msam_pkg::CMD_TICK, 3'd0, 16'sd0);
    drain();

    // Load one source with a backlog that outlasts several short frames.
    write_reg(msam_pkg::REG_FRAME_LEN, 11'd0);
    write_reg(msam_pkg::REG_DROP_LIMIT, 11'd2047);
    for (int i = 0; i < 30; i++) send_request(msam_pkg::CMD_PUSH, 3'd3, rand_sample());
    send_request(msam_pkg::CMD_TICK, 3'd0, 16'sd0);
    send_request(msam_pkg::CMD_TICK, 3'd0, 16'sd0);
    drain();
    write_reg(msam_pkg::REG_FRAME_LEN, 11'd127);
    write_reg(msam_pkg::REG_DROP_LIMIT, 11'd0);
    send_request(msam_pkg::CMD_TICK, 3'd0, 16'sd0);
    send_request(msam_pkg::CMD_TICK, 3'd0, 16'sd0);
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: fl = 11'd1;
        1: fl = 11'd64;
        default: fl = 11'($urandom_range(0, 127));
      endcase
      if ($urandom_range(0, 2) == 0) fl = fl | 11'($urandom_range(1, 15) << 7);
      case (p % 3)
        0: dl = 11'd1024;
        1: dl = 11'd0;
        default: dl = 11'($urandom_range(0, 40));
      endcase
      write_reg(msam_pkg::REG_FRAME_LEN, fl);
      write_reg(msam_pkg::REG_DROP_LIMIT, dl);
      random_burst(32, (fl[6:0] > 16) ? 5 : 15);
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
